// ----- design/mexp_pkg.sv -----
// mexp_pkg: shared types, constants and arithmetic helpers for modular exponentiation
package mexp_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam cnt_t  CNT_LAST = cnt_t'(DATA_WIDTH - 1);
  localparam word_t WORD_ONE = word_t'(1);

  // request item
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] exponent;
    logic [63:0] modulus;
  } req_item_t;

  // response item
  typedef struct packed {
    logic [63:0] power_result;
    logic        bad_modulus;
  } rsp_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED_INIT,
    ST_RED_STEP,
    ST_RED_END,
    ST_BIT_INIT,
    ST_BIT_STEP,
    ST_BIT_END,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_RED_END,
    OP_BIT_END,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   reduce;
  } dp_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic e_zero;
    logic step_last;
    logic e_last;
  } dp_status_t;

  // (a + b) mod m for a, b below m, m nonzero
  function automatic word_t add_mod(word_t a, word_t b, word_t m);
    logic [DATA_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  // one interleaved multiplier step: acc = 2*acc (+ x) mod m
  function automatic word_t mul_step(word_t acc, word_t x, logic ybit, word_t m);
    word_t d;
    d = add_mod(acc, acc, m);
    if (ybit) begin
      d = add_mod(d, x, m);
    end
    return d;
  endfunction

endpackage

// ----- design/mexp_ctrl.sv -----
// mexp_ctrl: sequencing state machine for the square-and-multiply loop
module mexp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  mexp_pkg::dp_status_t status,
  output mexp_pkg::dp_cmd_t    cmd
);
  import mexp_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        rsp_valid_next;
  logic        slot_free;

  // output slot can take a new item when empty or being drained
  assign slot_free = !rsp_valid || !rsp_stall;

  // state register and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.m_zero || status.e_zero) state_next = ST_FINISH;
        else state_next = ST_RED_INIT;
      end
      ST_RED_INIT: state_next = ST_RED_STEP;
      ST_RED_STEP: begin
        if (status.step_last) state_next = ST_RED_END;
      end
      ST_RED_END:  state_next = ST_BIT_INIT;
      ST_BIT_INIT: state_next = ST_BIT_STEP;
      ST_BIT_STEP: begin
        if (status.step_last) state_next = ST_BIT_END;
      end
      ST_BIT_END: begin
        if (status.e_last) state_next = ST_FINISH;
        else state_next = ST_BIT_INIT;
      end
      ST_FINISH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd.op         = OP_NONE;
    cmd.reduce     = 1'b0;
    req_stall      = 1'b1;
    rsp_valid_next = rsp_valid && rsp_stall;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) cmd.op = OP_LOAD;
      end
      ST_RED_INIT: begin
        cmd.op     = OP_MUL_INIT;
        cmd.reduce = 1'b1;
      end
      ST_RED_STEP: begin
        cmd.op     = OP_MUL_STEP;
        cmd.reduce = 1'b1;
      end
      ST_RED_END:  cmd.op = OP_RED_END;
      ST_BIT_INIT: cmd.op = OP_MUL_INIT;
      ST_BIT_STEP: cmd.op = OP_MUL_STEP;
      ST_BIT_END:  cmd.op = OP_BIT_END;
      ST_FINISH: begin
        if (slot_free) begin
          cmd.op         = OP_FINISH;
          rsp_valid_next = 1'b1;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- design/mexp_dp.sv -----
// mexp_dp: operand registers and two bit-serial modular multipliers
module mexp_dp (
  input  logic                 clk,
  input  mexp_pkg::dp_cmd_t    cmd,
  input  mexp_pkg::req_item_t  req,
  output mexp_pkg::dp_status_t status,
  output mexp_pkg::rsp_item_t  rsp
);
  import mexp_pkg::*;

  word_t b;
  word_t e;
  word_t m;
  word_t r;
  word_t acc_r;
  word_t acc_b;
  word_t y_sh;
  cnt_t  cnt;
  word_t x_b;
  word_t in_b;
  word_t in_e;
  word_t in_m;

  assign in_b = req.base[DATA_WIDTH-1:0];
  assign in_e = req.exponent[DATA_WIDTH-1:0];
  assign in_m = req.modulus[DATA_WIDTH-1:0];

  // reduction of the base runs as 1 * base mod m
  assign x_b = cmd.reduce ? WORD_ONE : b;

  // status toward the controller
  assign status.m_zero    = (m == '0);
  assign status.e_zero    = (e == '0);
  assign status.step_last = (cnt == CNT_LAST);
  assign status.e_last    = (e[DATA_WIDTH-1:1] == '0);

  // operand and multiplier registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        b <= in_b;
        e <= in_e;
        m <= in_m;
        // zero exponent gives 1 unreduced, else 1 mod m
        r <= ((in_e == '0) || (in_m != WORD_ONE)) ? WORD_ONE : '0;
      end
      OP_MUL_INIT: begin
        acc_r <= '0;
        acc_b <= '0;
        y_sh  <= b;
        cnt   <= '0;
      end
      OP_MUL_STEP: begin
        acc_r <= mul_step(acc_r, r, y_sh[DATA_WIDTH-1], m);
        acc_b <= mul_step(acc_b, x_b, y_sh[DATA_WIDTH-1], m);
        y_sh  <= {y_sh[DATA_WIDTH-2:0], 1'b0};
        cnt   <= cnt + cnt_t'(1);
      end
      OP_RED_END: begin
        b <= acc_b;
      end
      OP_BIT_END: begin
        if (e[0]) r <= acc_r;
        b <= acc_b;
        e <= {1'b0, e[DATA_WIDTH-1:1]};
      end
      OP_FINISH: begin
        rsp.power_result <= 64'(status.m_zero ? '0 : r);
        rsp.bad_modulus  <= status.m_zero;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/modular_exponentiation.sv -----
// modular_exponentiation: top level joining the controller and the datapath
//
//   channel | valid     | stall     | payload            | direction
//   --------+-----------+-----------+--------------------+----------
//   request | req_valid | req_stall | req  (req_item_t)  | into block
//   result  | rsp_valid | rsp_stall | rsp  (rsp_item_t)  | out of block
//
// One item at a time. A zero modulus or zero exponent goes straight from the check to
// the result. Otherwise the base is first reduced, then each exponent bit up to the
// highest set one takes one pass of the 64-step bit-serial multipliers. The result
// sits in an output register: the next item is taken while it waits; only the final
// write-back waits for a free slot. Reset is synchronous.
module modular_exponentiation (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mexp_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mexp_pkg::rsp_item_t rsp
);
  import mexp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic
  mexp_dp u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .req    (req),
    .status (status),
    .rsp    (rsp)
  );

endmodule

// ----- dv/tb_modular_exponentiation.sv -----
// tb_modular_exponentiation: self-checking testbench for the modular exponentiation block
`timescale 1ns / 100ps

module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned LONG_HOLD   = 700;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam logic [63:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] TOP_BIT     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] BIG_PRIME   = 64'hffff_ffff_ffff_ffc5;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  // expected results in arrival order
  rsp_item_t   power_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // idling controls for the sender (gaps) and the receiver (stalls, long hold)
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  bit long_hold = 1'b0;

  modular_exponentiation i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // base^exponent mod modulus with exact 128-bit products
  function automatic rsp_item_t expected_power(req_item_t item);
    rsp_item_t    r;
    logic [63:0]  b;
    logic [63:0]  e;
    logic [63:0]  m;
    logic [63:0]  acc;
    logic [127:0] prod;
    b = item.base;
    e = item.exponent;
    m = item.modulus;
    r.bad_modulus = 1'b0;
    if (m == 64'd0) begin
      r.power_result = 64'd0;
      r.bad_modulus  = 1'b1;
    end else if (e == 64'd0) begin
      // zero exponent gives one even for modulus one
      r.power_result = 64'd1;
    end else begin
      b = b % m;
      acc = (m == 64'd1) ? 64'd0 : 64'd1;
      while (e != 64'd0) begin
        if (e[0]) begin
          prod = ({64'd0, acc} * {64'd0, b}) % {64'd0, m};
          acc = prod[63:0];
        end
        e = e >> 1;
        prod = ({64'd0, b} * {64'd0, b}) % {64'd0, m};
        b = prod[63:0];
      end
      r.power_result = acc;
    end
    return r;
  endfunction

  // random word with the given number of low bits populated
  function automatic logic [63:0] rand_bits(int unsigned nbits);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (nbits < 64) begin
      w = w & ((64'd1 << nbits) - 64'd1);
    end
    return w;
  endfunction

  function automatic logic [63:0] rand_modulus();
    logic [63:0] m;
    case ($urandom_range(0, 9))
      0: m = 64'd0;
      1: m = 64'd1;
      2: m = ALL_ONES;
      3: m = 64'd1 << $urandom_range(1, 63);
      4, 5: m = rand_bits($urandom_range(2, 16));
      default: m = rand_bits(64);
    endcase
    return m;
  endfunction

  function automatic logic [63:0] rand_base();
    logic [63:0] b;
    case ($urandom_range(0, 7))
      0: b = 64'd0;
      1: b = ALL_ONES;
      default: b = rand_bits(64);
    endcase
    return b;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_modular_exponentiation NOT OK");
      $finish;
    end
  end

  // predict on every accepted request, compare every accepted result
  always @(posedge clk) begin : check_results
    rsp_item_t want;
    if (!rst && req_valid && !req_stall) begin
      power_q.push_back(expected_power(req));
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      if (power_q.size() == 0) begin
        $display("%0t: unexpected item: power_result %h bad_modulus %b",
                 $time, rsp.power_result, rsp.bad_modulus);
        mismatch_count++;
      end else begin
        want = power_q.pop_front();
        if (rsp.power_result !== want.power_result) begin
          $display("%0t: power_result mismatch: expected %h actual %h",
                   $time, want.power_result, rsp.power_result);
          mismatch_count++;
        end
        if (rsp.bad_modulus !== want.bad_modulus) begin
          $display("%0t: bad_modulus mismatch: expected %b actual %b",
                   $time, want.bad_modulus, rsp.bad_modulus);
          mismatch_count++;
        end
      end
    end
  end

  // result side: random stall before each item, optional long hold-off
  initial begin : result_receiver
    int unsigned hold_cycles;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      hold_cycles = stall_on ? $urandom_range(0, 8) : 0;
      if (long_hold) begin
        hold_cycles = hold_cycles + LONG_HOLD;
        long_hold = 1'b0;
      end
      if (hold_cycles != 0) begin
        rsp_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      @(negedge clk);
    end
  end

  // offer one item after a random gap and wait until it is taken
  task automatic send_request(input logic [63:0] b, input logic [63:0] e,
                              input logic [63:0] m);
    int unsigned gap;
    req_item_t   item;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    item.base     = b;
    item.exponent = e;
    item.modulus  = m;
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic wait_drained();
    while (power_q.size() != 0) @(posedge clk);
  endtask

  // zero modulus, zero exponent, modulus one and small known values
  task automatic test_special_cases();
    send_request(64'd5, 64'd3, 64'd0);
    send_request(ALL_ONES, ALL_ONES, 64'd0);
    send_request(64'd0, 64'd0, 64'd0);
    send_request(64'd7, 64'd0, 64'd1);
    send_request(64'd7, 64'd0, ALL_ONES);
    send_request(64'd0, 64'd0, 64'd13);
    send_request(ALL_ONES, 64'd5, 64'd1);
    send_request(64'd0, 64'd5, 64'd13);
    send_request(64'd3, 64'd5, 64'd7);
    send_request(64'd10, 64'd1, 64'd7);
    send_request(ALL_ONES, 64'd2, 64'd2);
  endtask

  // full-width operands, with full-width and small exponents
  task automatic test_extremes();
    send_request(ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(64'd2, ALL_ONES, BIG_PRIME);
    send_request(ALL_ONES, TOP_BIT, BIG_PRIME);
    send_request(64'd123456789, TOP_BIT | 64'd1, TOP_BIT);
    send_request(TOP_BIT, 64'd2, ALL_ONES);
    send_request(ALL_ONES, 64'd3, TOP_BIT | 64'd1);
  endtask

  // receiver holds off long enough for the block to back up its input
  task automatic test_backpressure();
    int i;
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    long_hold = 1'b1;
    for (i = 0; i < 8; i++) begin
      send_request(rand_base(), rand_bits($urandom_range(0, 4)), rand_modulus());
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // random operands with short exponents
  task automatic test_random_short(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_request(rand_base(), rand_bits($urandom_range(0, 10)), rand_modulus());
    end
  endtask

  // random operands with full-width exponents, top bit mostly set
  task automatic test_random_full(input int count);
    int i;
    logic [63:0] e;
    for (i = 0; i < count; i++) begin
      e = rand_bits(64);
      if ($urandom_range(0, 3) != 0) begin
        e = e | TOP_BIT;
      end
      send_request(rand_base(), e, rand_modulus());
    end
  endtask

  // back-to-back items with no idling on either side
  task automatic test_no_idle(input int count);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    test_random_short(count);
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_special_cases();
    test_extremes();
    test_backpressure();
    test_random_short(80);
    test_no_idle(20);
    test_random_full(8);

    @(negedge clk);
    req_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && power_q.size() == 0) begin
      $display("tb_modular_exponentiation OK");
    end else begin
      $display("tb_modular_exponentiation NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/mexp_pkg.sv
design/mexp_ctrl.sv
design/mexp_dp.sv
design/modular_exponentiation.sv
dv/tb_modular_exponentiation.sv
